// File: hw/rtl/three_class_strict_priority_min_queue_top_macros.svh
// Assertion macros shared by the checker of the three-class priority queue.
// Depends on nothing; the including file supplies clock and reset names.
`ifndef THREE_CLASS_STRICT_PRIORITY_MIN_QUEUE_TOP_MACROS_SVH
`define THREE_CLASS_STRICT_PRIORITY_MIN_QUEUE_TOP_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define TCQ_ASSERT_IMPL(label, clk, rst, lhs, rhs) \
  label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) \
    else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define TCQ_ASSERT_NEXT(label, clk, rst, lhs, rhs) \
  label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) \
    else $error("assertion failed");

// Next-cycle implication that also holds across reset.
`define TCQ_ASSERT_NEXT_ALWAYS(label, clk, lhs, rhs) \
  label: assert property (@(posedge clk) (lhs) |=> (rhs)) \
    else $error("assertion failed");

`endif

// File: hw/rtl/tcq_pkg.sv
// Package of the three-class priority queue: sizes, codes and state type.
// Depends on nothing.
package tcq_pkg;

  localparam int CAPACITY = 1024;
  localparam int KEY_BITS = 32;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int SUM_W    = IDX_W + 1;
  localparam int ADDR_W   = IDX_W + 2;

  localparam logic       OP_INSERT = 1'b0;
  localparam logic       OP_SERVE  = 1'b1;
  localparam logic [1:0] CLS_BLUE  = 2'd0;
  localparam logic [1:0] CLS_PINK  = 2'd1;
  localparam logic [1:0] CLS_GREEN = 2'd2;
  localparam logic [1:0] CLS_NONE  = 2'd3;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PROBE,
    S_CMP,
    S_DECIDE,
    S_SHIFT,
    S_SHWR,
    S_SRV,
    S_EMPTY
  } state_t;

endpackage

// File: hw/rtl/tcq_item_if.sv
// Channel interfaces of the three-class priority queue: requests and results.
// Depends on tcq_pkg.
interface tcq_item_if;
  logic                               valid;
  logic                               ready;
  logic                               op;
  logic [1:0]                         item_class;
  logic signed [tcq_pkg::KEY_BITS-1:0] key;
  modport source (output valid, op, item_class, key, input ready);
  modport sink   (input valid, op, item_class, key, output ready);
endinterface

interface tcq_result_if;
  logic                               valid;
  logic                               ready;
  logic [1:0]                         served_class;
  logic signed [tcq_pkg::KEY_BITS-1:0] served_key;
  logic                               all_empty;
  modport source (output valid, served_class, served_key, all_empty, input ready);
  modport sink   (input valid, served_class, served_key, all_empty, output ready);
endinterface

// File: hw/rtl/three_class_strict_priority_min_queue_top.sv
// Three-class strict-priority minimum queue: one key memory, sorted rings per class.
// Depends on tcq_pkg and the channel interfaces in tcq_item_if.sv.
//
// Each class keeps its keys sorted ascending in a ring of CAPACITY entries in one
// synchronous memory with a registered read port. A serve reads the head of the first
// non-empty class and waits for a free result slot. An insert into an empty class
// writes the key directly; otherwise a binary search over the n keys of the class finds
// its place, each key from that place on is moved up one entry to make room, and a final
// write stores the key. A duplicate key, class code three, or a key larger than all
// keys of a full class ends the insert without change. A serve on empty classes
// returns all_empty.
module three_class_strict_priority_min_queue_top (
  input  logic         clk,
  input  logic         rst,
  tcq_item_if.sink     in_item,
  tcq_result_if.source out_result
);

  localparam int CAP = tcq_pkg::CAPACITY;
  localparam int IW  = tcq_pkg::IDX_W;
  localparam int CW  = tcq_pkg::CNT_W;
  localparam int SW  = tcq_pkg::SUM_W;
  localparam int AW  = tcq_pkg::ADDR_W;
  localparam int KW  = tcq_pkg::KEY_BITS;

  function automatic logic [AW-1:0] ring_addr(input logic [1:0] cls,
                                               input logic [IW-1:0] hd,
                                               input logic [CW-1:0] idx);
    logic [SW-1:0] sum;
    logic [SW-1:0] wrapped;
    sum     = SW'(hd) + SW'(idx);
    wrapped = (sum >= SW'(CAP)) ? (sum - SW'(CAP)) : sum;
    return {cls, wrapped[IW-1:0]};
  endfunction

  logic signed [KW-1:0] mem [4*(2**IW)];
  logic signed [KW-1:0] rdata;
  logic                 mem_re;
  logic                 mem_we;
  logic [AW-1:0]        mem_raddr;
  logic [AW-1:0]        mem_waddr;
  logic signed [KW-1:0] mem_wdata;

  tcq_pkg::state_t      st;
  tcq_pkg::state_t      st_next;
  logic [1:0]           cur_cls;
  logic signed [KW-1:0] cur_key;
  logic [CW-1:0]        lo;
  logic [CW-1:0]        hi;
  logic [CW-1:0]        mid;
  logic [CW-1:0]        mid_c;
  logic [CW:0]          mid_sum;
  logic                 found;
  logic [CW-1:0]        n_eff;
  logic [CW-1:0]        i_idx;
  logic [IW-1:0]        head  [3];
  logic [CW-1:0]        count [3];
  logic [1:0]           sel_cls;
  logic                 none_left;
  logic                 in_xfer;
  logic                 slot_free;
  logic                 cls_ok;
  logic                 cur_full;
  logic [AW-1:0]        head_step;
  logic                 out_load;

  logic                 out_valid;
  logic [1:0]           out_cls;
  logic signed [KW-1:0] out_key;
  logic                 out_empty;

  assign in_xfer   = in_item.valid && in_item.ready;
  assign slot_free = !out_valid || out_result.ready;
  assign cls_ok    = in_item.item_class != tcq_pkg::CLS_NONE;
  assign mid_sum   = (CW+1)'(lo) + (CW+1)'(hi);
  assign mid_c     = mid_sum[CW:1];
  assign cur_full  = count[cur_cls] == CW'(CAP);
  assign head_step = ring_addr(cur_cls, head[cur_cls], CW'(1));
  assign out_load  = slot_free && (st == tcq_pkg::S_SRV || st == tcq_pkg::S_EMPTY);

  always_comb begin
    sel_cls   = tcq_pkg::CLS_BLUE;
    none_left = 1'b0;
    if (count[0] != '0) begin
      sel_cls = tcq_pkg::CLS_BLUE;
    end else if (count[1] != '0) begin
      sel_cls = tcq_pkg::CLS_PINK;
    end else if (count[2] != '0) begin
      sel_cls = tcq_pkg::CLS_GREEN;
    end else begin
      none_left = 1'b1;
    end
  end

  always_comb begin
    st_next = st;
    unique case (st)
      tcq_pkg::S_IDLE: begin
        if (in_xfer) begin
          if (in_item.op == tcq_pkg::OP_SERVE) begin
            st_next = none_left ? tcq_pkg::S_EMPTY : tcq_pkg::S_SRV;
          end else if (cls_ok && count[in_item.item_class[1:0]] != '0) begin
            st_next = tcq_pkg::S_PROBE;
          end
        end
      end
      tcq_pkg::S_PROBE:  st_next = (lo < hi) ? tcq_pkg::S_CMP : tcq_pkg::S_DECIDE;
      tcq_pkg::S_CMP:    st_next = tcq_pkg::S_PROBE;
      tcq_pkg::S_DECIDE: begin
        if (found || (cur_full && lo == count[cur_cls])) begin
          st_next = tcq_pkg::S_IDLE;
        end else begin
          st_next = tcq_pkg::S_SHIFT;
        end
      end
      tcq_pkg::S_SHIFT:  st_next = (i_idx > lo) ? tcq_pkg::S_SHWR : tcq_pkg::S_IDLE;
      tcq_pkg::S_SHWR:   st_next = tcq_pkg::S_SHIFT;
      tcq_pkg::S_SRV:    st_next = slot_free ? tcq_pkg::S_IDLE : tcq_pkg::S_SRV;
      tcq_pkg::S_EMPTY:  st_next = slot_free ? tcq_pkg::S_IDLE : tcq_pkg::S_EMPTY;
      default:           st_next = tcq_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    in_item.ready = 1'b0;
    mem_re        = 1'b0;
    mem_we        = 1'b0;
    mem_raddr     = '0;
    mem_waddr     = '0;
    mem_wdata     = cur_key;
    unique case (st)
      tcq_pkg::S_IDLE: begin
        in_item.ready = 1'b1;
        if (in_xfer && in_item.op == tcq_pkg::OP_SERVE && !none_left) begin
          mem_re    = 1'b1;
          mem_raddr = ring_addr(sel_cls, head[sel_cls], '0);
        end
        if (in_xfer && in_item.op == tcq_pkg::OP_INSERT && cls_ok &&
            count[in_item.item_class[1:0]] == '0) begin
          mem_we    = 1'b1;
          mem_waddr = ring_addr(in_item.item_class, head[in_item.item_class[1:0]], '0);
          mem_wdata = in_item.key;
        end
      end
      tcq_pkg::S_PROBE: begin
        if (lo < hi) begin
          mem_re    = 1'b1;
          mem_raddr = ring_addr(cur_cls, head[cur_cls], mid_c);
        end
      end
      tcq_pkg::S_SHIFT: begin
        if (i_idx > lo) begin
          mem_re    = 1'b1;
          mem_raddr = ring_addr(cur_cls, head[cur_cls], i_idx - 1'b1);
        end else begin
          mem_we    = 1'b1;
          mem_waddr = ring_addr(cur_cls, head[cur_cls], lo);
        end
      end
      tcq_pkg::S_SHWR: begin
        mem_we    = 1'b1;
        mem_waddr = ring_addr(cur_cls, head[cur_cls], i_idx);
        mem_wdata = rdata;
      end
      tcq_pkg::S_CMP, tcq_pkg::S_DECIDE, tcq_pkg::S_SRV, tcq_pkg::S_EMPTY: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata <= mem[mem_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st        <= tcq_pkg::S_IDLE;
      out_valid <= 1'b0;
      for (int c = 0; c < 3; c++) begin
        head[c]  <= '0;
        count[c] <= '0;
      end
    end else begin
      st <= st_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_result.ready) begin
        out_valid <= 1'b0;
      end
      unique case (st)
        tcq_pkg::S_IDLE: begin
          if (in_xfer) begin
            cur_key <= in_item.key;
            lo      <= '0;
            found   <= 1'b0;
            if (in_item.op == tcq_pkg::OP_SERVE) begin
              cur_cls <= sel_cls;
            end else if (cls_ok) begin
              cur_cls <= in_item.item_class;
              hi      <= count[in_item.item_class[1:0]];
              if (count[in_item.item_class[1:0]] == '0) begin
                count[in_item.item_class[1:0]] <= CW'(1);
              end
            end
          end
        end
        tcq_pkg::S_PROBE: begin
          mid <= mid_c;
        end
        tcq_pkg::S_CMP: begin
          if (rdata == cur_key) begin
            found <= 1'b1;
          end
          if (rdata < cur_key) begin
            lo <= mid + 1'b1;
          end else begin
            hi <= mid;
          end
        end
        tcq_pkg::S_DECIDE: begin
          n_eff <= cur_full ? count[cur_cls] - 1'b1 : count[cur_cls];
          i_idx <= cur_full ? count[cur_cls] - 1'b1 : count[cur_cls];
        end
        tcq_pkg::S_SHIFT: begin
          if (i_idx <= lo) begin
            count[cur_cls] <= n_eff + 1'b1;
          end
        end
        tcq_pkg::S_SHWR: begin
          i_idx <= i_idx - 1'b1;
        end
        tcq_pkg::S_SRV: begin
          if (slot_free) begin
            out_cls        <= cur_cls;
            out_key        <= rdata;
            out_empty      <= 1'b0;
            head[cur_cls]  <= head_step[IW-1:0];
            count[cur_cls] <= count[cur_cls] - 1'b1;
          end
        end
        tcq_pkg::S_EMPTY: begin
          if (slot_free) begin
            out_cls   <= tcq_pkg::CLS_BLUE;
            out_key   <= '0;
            out_empty <= 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign out_result.valid        = out_valid;
  assign out_result.served_class = out_cls;
  assign out_result.served_key   = out_key;
  assign out_result.all_empty    = out_empty;

endmodule

// File: hw/rtl/tcq_checker.sv
// Port checker of the three-class priority queue, bound to the top level.
// Depends on tcq_pkg and the assertion macros header.
`include "three_class_strict_priority_min_queue_top_macros.svh"

module tcq_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [1:0]                  served_class,
  input logic [tcq_pkg::KEY_BITS-1:0] served_key,
  input logic                        all_empty
);

  `TCQ_ASSERT_NEXT(a_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(served_key))
  `TCQ_ASSERT_IMPL(a_empty_zero, clk, rst, out_valid && all_empty, served_class == tcq_pkg::CLS_BLUE && served_key == '0)
  `TCQ_ASSERT_IMPL(a_class_ok, clk, rst, out_valid, served_class != tcq_pkg::CLS_NONE)
  `TCQ_ASSERT_NEXT_ALWAYS(a_reset_quiet, clk, rst, !out_valid)

endmodule

bind three_class_strict_priority_min_queue_top tcq_checker u_tcq_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (out_result.valid),
  .out_ready    (out_result.ready),
  .served_class (out_result.served_class),
  .served_key   (out_result.served_key),
  .all_empty    (out_result.all_empty)
);
